// ===== src/uvst_pkg.sv =====
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared types and codes for the unique value set table.
// ----------------------------------------------------------------------------
package uvst_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int OP_W         = 3;
	localparam int VAL_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_REPLACE = 3'd2,
		OP_LOOKUP  = 3'd3,
		OP_CLEAR   = 3'd4
	} op_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_ABSENT  = 2'd2,
		STAT_FULL    = 2'd3
	} status_code_t;

	typedef struct packed {
		logic                success;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} result_t;

	// Load request from the control engine to the output register.
	typedef struct packed {
		logic    load;
		result_t result;
	} rsp_load_t;

endpackage

// ===== src/uvst_req_if.sv =====
// ----------------------------------------------------------------------------
// uvst_req_if
// Request channel: operation code and operand values.
// ----------------------------------------------------------------------------
interface uvst_req_if;
	import uvst_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;
	logic signed [VAL_W-1:0] new_value;

	modport source (output valid, output op, output value, output new_value, input ready);
	modport sink (input valid, input op, input value, input new_value, output ready);
endinterface

// ===== src/uvst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// uvst_rsp_if
// Response channel: success flag, status code and held count.
// ----------------------------------------------------------------------------
interface uvst_rsp_if;
	import uvst_pkg::*;

	logic                valid;
	logic                ready;
	logic                success;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output success, output status, output entry_count, input ready);
	modport sink (input valid, input success, input status, input entry_count, output ready);
endinterface

// ===== src/uvst_out_reg.sv =====
// ----------------------------------------------------------------------------
// uvst_out_reg
// Output register for the response channel; holds one finished transaction
// so the engine can start on the next request while it waits.
// ----------------------------------------------------------------------------
module uvst_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  uvst_pkg::rsp_load_t load,
	output logic                free,
	uvst_rsp_if.source          rsp
);
	import uvst_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load.load && free) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load.load && free) begin
			data_q <= load.result;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.success     = data_q.success;
	assign rsp.status      = data_q.status;
	assign rsp.entry_count = data_q.entry_count;
endmodule

// ===== src/unique_value_set_table_top.sv =====
// ----------------------------------------------------------------------------
// unique_value_set_table_top
// Bounded set of distinct 32-bit values kept in a single-port slot memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | op, value, new_value
//  rsp     | out       | success, status, entry_count
//
//  Insert, remove, replace and lookup read every slot once through the memory
//  port, drain the read pipe and decide; a successful insert, remove or replace
//  then writes one slot back. Clear writes every slot through the same port.
//  Unused op codes answer without a memory access. After reset the memory is
//  swept, every slot cleared, before the first request is taken.
//  A stalled response sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module unique_value_set_table_top #(
	parameter int CAPACITY = uvst_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	uvst_req_if.sink   req,
	uvst_rsp_if.source rsp
);
	import uvst_pkg::*;

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int WORD_W = VAL_W + 1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RESP
	} state_t;

	state_t state_q;

	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] nval_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    held_q;
	logic             clear_q;

	logic             rd_s1;
	logic [AW-1:0]    addr_s1;
	logic [WORD_W-1:0] rdata_s1;

	logic             hit_val_q;
	logic [AW-1:0]    hit_idx_q;
	logic             hit_nval_q;
	logic             free_found_q;
	logic [AW-1:0]    free_idx_q;

	result_t          res_q;

	// Slot memory: bit VAL_W is the valid flag.
	logic [WORD_W-1:0] mem [CAPACITY];

	logic              mem_re;
	logic              mem_we;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;

	// Decision after the scan.
	logic              d_success;
	logic [STATUS_W-1:0] d_status;
	logic              d_write;
	logic [AW-1:0]     d_idx;
	logic [WORD_W-1:0] d_word;
	logic [CW-1:0]     d_held;

	logic      out_free;
	rsp_load_t load;

	always_comb begin
		d_success = 1'b0;
		d_status  = STAT_OK;
		d_write   = 1'b0;
		d_idx     = hit_idx_q;
		d_word    = {1'b1, nval_q};
		d_held    = held_q;
		case (op_q)
			OP_INSERT: begin
				if (hit_val_q) begin
					d_status = STAT_PRESENT;
				end else if (!free_found_q) begin
					d_status = STAT_FULL;
				end else begin
					d_success = 1'b1;
					d_write   = 1'b1;
					d_idx     = free_idx_q;
					d_word    = {1'b1, val_q};
					d_held    = held_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (!hit_val_q) begin
					d_status = STAT_ABSENT;
				end else begin
					d_success = 1'b1;
					d_write   = 1'b1;
					d_word    = {1'b0, val_q};
					d_held    = held_q - CW'(1);
				end
			end
			OP_REPLACE: begin
				if (hit_nval_q) begin
					d_status = STAT_PRESENT;
				end else if (!hit_val_q) begin
					d_status = STAT_ABSENT;
				end else begin
					d_success = 1'b1;
					d_write   = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (hit_val_q) begin
					d_success = 1'b1;
				end else begin
					d_status = STAT_ABSENT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_re = (state_q == ST_SCAN) && (cnt_q != CW'(CAPACITY));
		raddr  = cnt_q[AW-1:0];
		mem_we = 1'b0;
		waddr  = cnt_q[AW-1:0];
		wdata  = '0;
		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
			end
			ST_DECIDE: begin
				mem_we = d_write;
				waddr  = d_idx;
				wdata  = d_word;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[raddr];
		end
		addr_s1 <= raddr;
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			cnt_q        <= '0;
			held_q       <= '0;
			clear_q      <= 1'b0;
			rd_s1        <= 1'b0;
			hit_val_q    <= 1'b0;
			hit_nval_q   <= 1'b0;
			free_found_q <= 1'b0;
			op_q         <= '0;
		end else begin
			rd_s1 <= mem_re;
			case (state_q)
				ST_SWEEP: begin
					if (cnt_q == CW'(CAPACITY - 1)) begin
						cnt_q  <= '0;
						held_q <= '0;
						if (clear_q) begin
							res_q   <= '{success: 1'b1, status: STAT_OK, entry_count: '0};
							clear_q <= 1'b0;
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q         <= req.op;
						val_q        <= req.value;
						nval_q       <= req.new_value;
						cnt_q        <= '0;
						hit_val_q    <= 1'b0;
						hit_nval_q   <= 1'b0;
						free_found_q <= 1'b0;
						case (req.op)
							OP_INSERT, OP_REMOVE, OP_REPLACE, OP_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							OP_CLEAR: begin
								clear_q <= 1'b1;
								state_q <= ST_SWEEP;
							end
							default: begin
								res_q   <= '{success: 1'b0, status: STAT_OK,
									entry_count: COUNT_W'(held_q)};
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_s1) begin
						if (rdata_s1[VAL_W] && rdata_s1[VAL_W-1:0] == val_q) begin
							hit_val_q <= 1'b1;
							hit_idx_q <= addr_s1;
						end
						if (rdata_s1[VAL_W] && rdata_s1[VAL_W-1:0] == nval_q) begin
							hit_nval_q <= 1'b1;
						end
						// Keep the lowest free slot only.
						if (!rdata_s1[VAL_W] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= addr_s1;
						end
					end else if (!mem_re) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					held_q  <= d_held;
					cnt_q   <= '0;
					res_q   <= '{success: d_success, status: d_status,
						entry_count: COUNT_W'(d_held)};
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign load = '{load: (state_q == ST_RESP), result: res_q};

	uvst_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.free   (out_free),
		.rsp    (rsp)
	);

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("held count exceeds capacity");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("slot memory written during a scan read");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_RESP))
		else $error("response raised without a finished request");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && op_q == OP_INSERT && d_success)
		|=> held_q == $past(held_q) + CW'(1))
		else $error("insert did not raise the held count");
endmodule
